// ----- design/xdlr_pkg.sv -----
package xdlr_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   localparam logic [1:0] CMD_STORE = 2'd0;
   localparam logic [1:0] CMD_FWD   = 2'd1;
   localparam logic [1:0] CMD_BWD   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NO_SNAP = 2'd2;
   localparam logic [1:0] STATUS_BAD_TGT = 2'd3;

   localparam int unsigned POS_W  = 7;
   localparam int unsigned BYTE_W = 8;

   localparam logic [POS_W-1:0] SNAPSHOT_AT_RESET = 7'd2;

endpackage

// ----- design/xdlr_ram.sv -----
module xdlr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/xor_delta_log_recovery.sv -----
// XOR delta log with point-in-time recovery.
// req channel: one item per command. A store appends one delta to the log and
// answers with the delta and its position; a recovery rebuilds the byte at
// req_target_position from the snapshot and the deltas between.
// rsp channel: exactly one item per store or recovery; the unused command
// gives none. csr channel: writes snapshot_at, always ready; the user is to
// write it only while idle, the block itself does not enforce it. A store, or
// any recovery rejected with an error status, shows its result the cycle
// after acceptance, and stores may follow back to back. A recovery reads one
// delta a cycle through the single read port of the log RAM in ST_WALK, then
// passes its result from ST_DONE into the output register; no new item is
// taken meanwhile. Reset clears the entry count, the snapshot and the output
// valid flag and sets snapshot_at to 2; the log RAM is not cleared, only
// entries already written are ever read.
// When rsp_ready is low the result holds in the output register; req_ready
// drops until it is taken, and a finished recovery waits for it too.
module xor_delta_log_recovery #(
   parameter int unsigned LOG_DEPTH = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_cmd,
   input  logic [xdlr_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic [xdlr_pkg::POS_W-1:0]       req_target_position,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [xdlr_pkg::BYTE_W-1:0]      rsp_result_byte,
   output logic [xdlr_pkg::POS_W-1:0]       rsp_position,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [xdlr_pkg::POS_W-1:0]       csr_snapshot_at
);

   localparam int unsigned AW = $clog2(LOG_DEPTH);
   localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
   // common width for position compares
   localparam int unsigned PW = (CW > xdlr_pkg::POS_W) ? CW : xdlr_pkg::POS_W;

   xdlr_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                 entry_count_ff, entry_count_in;
   logic [xdlr_pkg::BYTE_W-1:0]   last_byte_ff, last_byte_in;
   logic [xdlr_pkg::BYTE_W-1:0]   snap_byte_ff, snap_byte_in;
   logic                          snap_valid_ff, snap_valid_in;
   logic [AW-1:0]                 snap_pos_ff, snap_pos_in;
   logic [xdlr_pkg::POS_W-1:0]    snapshot_at_ff;
   logic [xdlr_pkg::BYTE_W-1:0]   acc_ff, acc_in;
   logic [AW-1:0]                 remaining_ff, remaining_in;
   logic [AW-1:0]                 walk_addr_ff, walk_addr_in;
   logic                          walk_down_ff, walk_down_in;
   logic                          rd_pending_ff, rd_pending_in;
   logic [xdlr_pkg::POS_W-1:0]    target_ff, target_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [xdlr_pkg::BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic [xdlr_pkg::POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;

   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [xdlr_pkg::BYTE_W-1:0]   ram_wdata;
   logic                          ram_re;
   logic [xdlr_pkg::BYTE_W-1:0]   ram_rdata;

   logic                          out_free;
   logic [PW-1:0]                 ext_count, ext_snap, ext_target, ext_at;
   logic [PW-1:0]                 fwd_diff, bwd_diff;
   logic [xdlr_pkg::BYTE_W-1:0]   store_delta;

   xdlr_ram #(
      .WIDTH (xdlr_pkg::BYTE_W),
      .DEPTH (LOG_DEPTH)
   ) u_log (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (walk_addr_ff),
      .rd_data (ram_rdata)
   );

   assign csr_ready = 1'b1;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign ext_count   = PW'(entry_count_ff);
   assign ext_snap    = PW'(snap_pos_ff);
   assign ext_target  = PW'(req_target_position);
   assign ext_at      = PW'(snapshot_at_ff);
   assign fwd_diff    = ext_target - ext_snap;
   assign bwd_diff    = ext_snap - ext_target;
   assign store_delta = (entry_count_ff == '0) ? req_data_byte
                                                : (req_data_byte ^ last_byte_ff);

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      last_byte_in   = last_byte_ff;
      snap_byte_in   = snap_byte_ff;
      snap_valid_in  = snap_valid_ff;
      snap_pos_in    = snap_pos_ff;
      acc_in         = acc_ff;
      remaining_in   = remaining_ff;
      walk_addr_in   = walk_addr_ff;
      walk_down_in   = walk_down_ff;
      rd_pending_in  = 1'b0;
      target_in      = target_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_status_in  = rsp_status_ff;
      ram_we         = 1'b0;
      ram_waddr      = AW'(entry_count_ff);
      ram_wdata      = store_delta;
      ram_re         = 1'b0;
      req_ready      = 1'b0;

      case (state_ff)
         xdlr_pkg::ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               case (req_cmd)
                  xdlr_pkg::CMD_STORE: begin
                     rsp_valid_in = 1'b1;
                     if (entry_count_ff == CW'(LOG_DEPTH)) begin
                        rsp_byte_in   = '0;
                        rsp_pos_in    = '0;
                        rsp_status_in = xdlr_pkg::STATUS_FULL;
                     end else begin
                        ram_we         = 1'b1;
                        last_byte_in   = req_data_byte;
                        entry_count_in = entry_count_ff + CW'(1);
                        if (ext_count == ext_at) begin
                           snap_byte_in  = req_data_byte;
                           snap_valid_in = 1'b1;
                           snap_pos_in   = AW'(entry_count_ff);
                        end
                        rsp_byte_in   = store_delta;
                        rsp_pos_in    = xdlr_pkg::POS_W'(ext_count);
                        rsp_status_in = xdlr_pkg::STATUS_OK;
                     end
                  end
                  xdlr_pkg::CMD_FWD,
                  xdlr_pkg::CMD_BWD: begin
                     rsp_byte_in = '0;
                     rsp_pos_in  = req_target_position;
                     if (!snap_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = xdlr_pkg::STATUS_NO_SNAP;
                     end else if ((req_cmd == xdlr_pkg::CMD_FWD &&
                                   (ext_target < ext_snap || ext_target >= ext_count)) ||
                                  (req_cmd == xdlr_pkg::CMD_BWD && ext_target > ext_snap)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = xdlr_pkg::STATUS_BAD_TGT;
                     end else begin
                        acc_in    = snap_byte_ff;
                        target_in = req_target_position;
                        state_in  = xdlr_pkg::ST_WALK;
                        if (req_cmd == xdlr_pkg::CMD_FWD) begin
                           // deltas after the snapshot, up to the target
                           walk_down_in = 1'b0;
                           remaining_in = AW'(fwd_diff);
                           walk_addr_in = snap_pos_ff + AW'(1);
                        end else begin
                           // deltas from the snapshot down, target excluded
                           walk_down_in = 1'b1;
                           remaining_in = AW'(bwd_diff);
                           walk_addr_in = snap_pos_ff;
                        end
                     end
                  end
                  default: begin
                     // unused command: taken, no result
                  end
               endcase
            end
         end
         xdlr_pkg::ST_WALK: begin
            if (rd_pending_ff) begin
               acc_in = acc_ff ^ ram_rdata;
            end
            if (remaining_ff != '0) begin
               ram_re        = 1'b1;
               rd_pending_in = 1'b1;
               remaining_in  = remaining_ff - AW'(1);
               walk_addr_in  = walk_down_ff ? (walk_addr_ff - AW'(1))
                                            : (walk_addr_ff + AW'(1));
            end else if (!rd_pending_ff) begin
               state_in = xdlr_pkg::ST_DONE;
            end
         end
         xdlr_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = acc_ff;
               rsp_pos_in    = target_ff;
               rsp_status_in = xdlr_pkg::STATUS_OK;
               state_in      = xdlr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xdlr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= xdlr_pkg::ST_IDLE;
         entry_count_ff <= '0;
         last_byte_ff   <= '0;
         snap_byte_ff   <= '0;
         snap_valid_ff  <= 1'b0;
         snap_pos_ff    <= '0;
         snapshot_at_ff <= xdlr_pkg::SNAPSHOT_AT_RESET;
         rd_pending_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         last_byte_ff   <= last_byte_in;
         snap_byte_ff   <= snap_byte_in;
         snap_valid_ff  <= snap_valid_in;
         snap_pos_ff    <= snap_pos_in;
         rd_pending_ff  <= rd_pending_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            snapshot_at_ff <= csr_snapshot_at;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      remaining_ff  <= remaining_in;
      walk_addr_ff  <= walk_addr_in;
      walk_down_ff  <= walk_down_in;
      target_ff     <= target_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_status      = rsp_status_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != xdlr_pkg::ST_IDLE |-> !req_ready)
      else $error("req_ready high during a recovery walk");

   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_pending_ff |-> state_ff == xdlr_pkg::ST_WALK)
      else $error("log read data arrived outside the walk");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CW'(LOG_DEPTH))
      else $error("entry count beyond log depth");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != xdlr_pkg::STATUS_OK |-> rsp_result_byte == '0)
      else $error("error result carries a non-zero byte");

endmodule
